@@ hdl/zcbf_pkg.sv @@
package zcbf_pkg;

  localparam int LEVEL_BITS_DEF     = 16;
  localparam int TIMER_BITS_DEF     = 16;
  localparam int FILTER_SAMPLES_DEF = 4;

  localparam int POWER_W    = 16;
  localparam int ZC_DELAY_W = 15;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    PH_CAL_RISE,
    PH_CAL_FALL,
    PH_RUN_EDGE,
    PH_RUN_DELAY
  } phase_t;

  // qualified edges from the noise filter
  typedef struct packed {
    logic rise;
    logic fall;
  } edge_t;

endpackage

@@ hdl/zero_cross_burst_fire_triac_core.sv @@
// A result shows on m_tvalid after its input transaction is accepted and has passed the
// input register, then the result register; a held result register stalls it.
// Throughput: one tick per cycle; input register and result register let the
// pipeline advance whenever the result register is empty or being taken.
// Reset (rst, synchronous): clears filter, timers, accumulator and heater;
// the block restarts calibration and waits for the first qualified rising edge.
module zero_cross_burst_fire_triac_core #(
  parameter int LEVEL_BITS     = zcbf_pkg::LEVEL_BITS_DEF,
  parameter int TIMER_BITS     = zcbf_pkg::TIMER_BITS_DEF,
  parameter int FILTER_SAMPLES = zcbf_pkg::FILTER_SAMPLES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [0] zcd_level, [16:1] power_level, rest zero
  input  logic [zcbf_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [0] heater_on, [1] decision_strobe, [2] calibrated, [17:3] zc_delay, rest zero
  output logic [zcbf_pkg::OUT_DATA_W-1:0] m_tdata
);

  logic                            in_valid;
  logic                            zcd_r;
  logic [zcbf_pkg::POWER_W-1:0]    power_r;
  logic                            advance;
  zcbf_pkg::edge_t                 edges;
  logic                            heater_on, decision_strobe, calibrated;
  logic [zcbf_pkg::ZC_DELAY_W-1:0] zc_delay;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      zcd_r   <= s_tdata[0];
      power_r <= s_tdata[zcbf_pkg::POWER_W:1];
    end
  end

  zcbf_filter #(
    .FILTER_SAMPLES(FILTER_SAMPLES)
  ) u_filter (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .raw  (zcd_r),
    .edges(edges)
  );

  zcbf_ctrl #(
    .LEVEL_BITS(LEVEL_BITS),
    .TIMER_BITS(TIMER_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .en             (advance),
    .edges          (edges),
    .power_level    (power_r),
    .heater_on      (heater_on),
    .decision_strobe(decision_strobe),
    .calibrated     (calibrated),
    .zc_delay       (zc_delay)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= zcbf_pkg::OUT_DATA_W'({zc_delay, calibrated, decision_strobe, heater_on});
    end
  end

endmodule

@@ hdl/zcbf_filter.sv @@
module zcbf_filter #(
  parameter int FILTER_SAMPLES = zcbf_pkg::FILTER_SAMPLES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           raw,
  output zcbf_pkg::edge_t edges
);

  localparam int CNT_W = $clog2(FILTER_SAMPLES + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(FILTER_SAMPLES - 1);

  logic [CNT_W-1:0] count, count_next;
  logic             level, level_next;

  always_comb begin
    count_next = count;
    level_next = level;
    edges      = '0;
    if (raw == level) begin
      count_next = '0;
    end else if (count >= LAST) begin
      count_next = '0;
      level_next = raw;
      edges.rise = raw;
      edges.fall = !raw;
    end else begin
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      level <= 1'b0;
    end else if (en) begin
      count <= count_next;
      level <= level_next;
    end
  end

endmodule

@@ hdl/zcbf_ctrl.sv @@
module zcbf_ctrl #(
  parameter int LEVEL_BITS = zcbf_pkg::LEVEL_BITS_DEF,
  parameter int TIMER_BITS = zcbf_pkg::TIMER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  zcbf_pkg::edge_t                 edges,
  input  logic [zcbf_pkg::POWER_W-1:0]    power_level,
  output logic                            heater_on,
  output logic                            decision_strobe,
  output logic                            calibrated,
  output logic [zcbf_pkg::ZC_DELAY_W-1:0] zc_delay
);

  zcbf_pkg::phase_t phase, phase_next;

  logic [TIMER_BITS-1:0] tick_counter, tick_counter_next, tick_inc;
  logic [TIMER_BITS-2:0] delay_value, delay_value_next;
  logic [LEVEL_BITS-1:0] phase_accumulator, phase_accumulator_next;
  logic [LEVEL_BITS-1:0] level;
  logic [LEVEL_BITS:0]   sum;
  logic                  heater_state, heater_state_next;
  logic                  expired;

  assign level    = LEVEL_BITS'(power_level);
  assign sum      = {1'b0, phase_accumulator} + {1'b0, level};
  assign expired  = tick_counter >= {1'b0, delay_value};
  // saturating pulse-width count
  assign tick_inc = (tick_counter != '1) ? tick_counter + 1'b1 : tick_counter;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      zcbf_pkg::PH_CAL_RISE:  if (edges.rise) phase_next = zcbf_pkg::PH_CAL_FALL;
      zcbf_pkg::PH_CAL_FALL:  if (edges.fall) phase_next = zcbf_pkg::PH_RUN_EDGE;
      zcbf_pkg::PH_RUN_EDGE:  if (edges.rise) phase_next = zcbf_pkg::PH_RUN_DELAY;
      zcbf_pkg::PH_RUN_DELAY: if (expired) phase_next = zcbf_pkg::PH_RUN_EDGE;
      default:                phase_next = zcbf_pkg::PH_CAL_RISE;
    endcase
  end

  always_comb begin
    tick_counter_next      = tick_counter;
    delay_value_next       = delay_value;
    phase_accumulator_next = phase_accumulator;
    heater_state_next      = heater_state;
    decision_strobe        = 1'b0;
    unique case (phase)
      zcbf_pkg::PH_CAL_RISE: begin
        if (edges.rise) tick_counter_next = '0;
      end
      zcbf_pkg::PH_CAL_FALL: begin
        tick_counter_next = tick_inc;
        if (edges.fall) begin
          delay_value_next  = tick_inc[TIMER_BITS-1:1];
          tick_counter_next = '0;
        end
      end
      zcbf_pkg::PH_RUN_EDGE: begin
        if (edges.rise) begin
          heater_state_next = 1'b0;
          tick_counter_next = '0;
        end
      end
      zcbf_pkg::PH_RUN_DELAY: begin
        if (expired) begin
          heater_state_next      = sum[LEVEL_BITS];
          phase_accumulator_next = sum[LEVEL_BITS-1:0];
          decision_strobe        = 1'b1;
          tick_counter_next      = '0;
        end else begin
          tick_counter_next = tick_counter + 1'b1;
        end
      end
      default: begin
        tick_counter_next = '0;
      end
    endcase
  end

  assign heater_on  = heater_state_next;
  assign calibrated = (phase_next == zcbf_pkg::PH_RUN_EDGE) ||
                      (phase_next == zcbf_pkg::PH_RUN_DELAY);
  assign zc_delay   = zcbf_pkg::ZC_DELAY_W'(delay_value_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= zcbf_pkg::PH_CAL_RISE;
      tick_counter      <= '0;
      delay_value       <= '0;
      phase_accumulator <= '0;
      heater_state      <= 1'b0;
    end else if (en) begin
      phase             <= phase_next;
      tick_counter      <= tick_counter_next;
      delay_value       <= delay_value_next;
      phase_accumulator <= phase_accumulator_next;
      heater_state      <= heater_state_next;
    end
  end

endmodule

@@ sim/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import zcbf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTED = 40;

  typedef struct {
    bit            heater;
    bit            strobe;
    bit            calib;
    bit [ZC_DELAY_W-1:0] zc_delay;
  } gate_drive_t;

  class triac_scoreboard;
    phase_t     ph;
    bit [2:0]   filt_cnt;
    bit         qual;
    bit [15:0]  ticks;
    bit [15:0]  delay;
    bit [15:0]  accum;
    bit         heater;
    gate_drive_t drive_q[$];
    int errors;
    int checked;
    int decisions;
    int fires;

    function new();
      ph = PH_CAL_RISE;
      filt_cnt = 0;
      qual = 0;
      ticks = 0;
      delay = 0;
      accum = 0;
      heater = 0;
    endfunction

    function int pending();
      return drive_q.size();
    endfunction

    // one accepted tick: advance the filter and the firing state, queue the gate drive
    function void note_tick(bit zcd, bit [POWER_W-1:0] pwr);
      bit rise;
      bit fall;
      bit strobe;
      bit [16:0] sum;
      gate_drive_t r;
      rise = 0;
      fall = 0;
      strobe = 0;
      if (zcd == qual) begin
        filt_cnt = 0;
      end else if (int'(filt_cnt) + 1 >= FILTER_SAMPLES_DEF) begin
        filt_cnt = 0;
        qual = zcd;
        rise = zcd;
        fall = !zcd;
      end else begin
        filt_cnt++;
      end
      case (ph)
        PH_CAL_RISE: begin
          if (rise) begin
            ticks = 0;
            ph = PH_CAL_FALL;
          end
        end
        PH_CAL_FALL: begin
          if (ticks != 16'hFFFF) ticks++;
          if (fall) begin
            delay = ticks >> 1;
            ticks = 0;
            ph = PH_RUN_EDGE;
          end
        end
        PH_RUN_EDGE: begin
          if (rise) begin
            heater = 0;
            ticks = 0;
            ph = PH_RUN_DELAY;
          end
        end
        default: begin
          if (ticks >= delay) begin
            sum = {1'b0, accum} + {1'b0, pwr};
            heater = sum[16];
            accum = sum[15:0];
            strobe = 1;
            ticks = 0;
            ph = PH_RUN_EDGE;
          end else begin
            ticks++;
          end
        end
      endcase
      r.heater = heater;
      r.strobe = strobe;
      r.calib = (ph == PH_RUN_EDGE) || (ph == PH_RUN_DELAY);
      r.zc_delay = delay[ZC_DELAY_W-1:0];
      drive_q.push_back(r);
    endfunction

    task report_mismatch(string what, int exp_v, int got_v);
      if (errors < MAX_PRINTED)
        $display("mismatch at result %0d, %s: expected %0d, got %0d",
                 checked, what, exp_v, got_v);
      errors++;
    endtask

    task check_result(logic [OUT_DATA_W-1:0] d);
      gate_drive_t e;
      if (drive_q.size() == 0) begin
        report_mismatch("result with no tick pending", 0, int'(d));
        return;
      end
      e = drive_q.pop_front();
      if (d[0] !== e.heater) report_mismatch("heater_on", e.heater, d[0]);
      if (d[1] !== e.strobe) report_mismatch("decision_strobe", e.strobe, d[1]);
      if (d[2] !== e.calib) report_mismatch("calibrated", e.calib, d[2]);
      if (d[17:3] !== e.zc_delay) report_mismatch("zc_delay", e.zc_delay, d[17:3]);
      if (d[OUT_DATA_W-1:18] !== '0) report_mismatch("padding", 0, d[OUT_DATA_W-1:18]);
      if (e.strobe) begin
        decisions++;
        if (e.heater) fires++;
      end
      checked++;
    endtask
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  triac_scoreboard sb;
  int src_idle_pct;
  int dst_idle_pct;
  int hold_cycles;
  int sent_ticks;
  int cycle_cnt;
  bit cur_level;

  zero_cross_burst_fire_triac_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 0;
  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d ticks still pending", cycle_cnt, sb.pending());
    $display("tb_top: FAIL");
    $finish;
  end

  // transaction monitor on both sides, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_tick(s_tdata[0], s_tdata[16:1]);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  // receiver: random backpressure, or a long hold-off when requested
  initial begin
    m_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_tready <= 0;
      end else begin
        m_tready <= ($urandom_range(99) >= dst_idle_pct);
      end
    end
  end

  function automatic bit [POWER_W-1:0] pick_power();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 16'h8000;
      3: return 16'h0001;
      default: return POWER_W'($urandom);
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_tick(bit zcd, bit [POWER_W-1:0] pwr);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {7'b0, pwr, zcd};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    sent_ticks++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // half-waves of random length, mixed with short glitches the filter must reject
  task automatic run_waves(int n);
    int done;
    int len;
    int kind;
    done = 0;
    while (done < n) begin
      kind = $urandom_range(99);
      if (kind < 12) begin
        len = $urandom_range(1, 3);
        repeat (len) send_tick(!cur_level, pick_power());
      end else begin
        cur_level = !cur_level;
        if (kind < 40) len = $urandom_range(4, 6);
        else if (kind < 90) len = $urandom_range(7, 20);
        else len = $urandom_range(21, 45);
        repeat (len) send_tick(cur_level, pick_power());
      end
      done += len;
    end
  endtask

  initial begin
    sb = new();
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    src_idle_pct = 29;
    dst_idle_pct = 54;
    hold_cycles = 0;
    sent_ticks = 0;
    cycle_cnt = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // pin high from reset counts as the first rising edge; a two-tick dropout
    // inside the calibration pulse must not end it
    repeat (6) send_tick(1'b1, '1);
    repeat (2) send_tick(1'b0, '0);
    repeat (8) send_tick(1'b1, 16'h8000);
    repeat (4) send_tick(1'b0, 16'h0001);
    cur_level = 0;

    run_waves(150);
    hold_cycles = 80;
    run_waves(150);

    src_idle_pct = 54;
    dst_idle_pct = 29;
    run_waves(150);
    wait_drained();
    run_waves(150);

    src_idle_pct = 0;
    dst_idle_pct = 0;
    run_waves(300);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d ticks, %0d firing decisions (%0d fired), zc_delay %0d,",
             sent_ticks, sb.decisions, sb.fires, sb.delay[ZC_DELAY_W-1:0]);
    $display("with filter glitches, edges inside the delay and stalls on both sides");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("%0d mismatches, %0d ticks never answered", sb.errors, sb.pending());
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

@@ zero_cross_burst_fire_triac_core.f @@
hdl/zcbf_pkg.sv
hdl/zcbf_filter.sv
hdl/zcbf_ctrl.sv
hdl/zero_cross_burst_fire_triac_core.sv
sim/tb_top.sv
